>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the waveform sample generator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/wsg_pkg.sv
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared types, constants and the sine table builder of the sample generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

  localparam int unsigned TABLE_LEN = 200;
  localparam int unsigned PHASE_W   = 8;
  localparam int unsigned DAC_W     = 12;
  localparam int unsigned DUTY_W    = 7;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 24;

  // sine: Q16 magnitude, 0..65536
  localparam int unsigned SIN_FRAC = 16;
  localparam int unsigned SIN_W    = SIN_FRAC + 1;
  localparam int unsigned PROD_W   = DAC_W + SIN_W;
  localparam int unsigned ACC_W    = DAC_W + SIN_FRAC + 3;
  localparam int unsigned WIDE_W   = DAC_W + 2;

  // triangle divider: dividend amp*phase, divisor up to TABLE_LEN
  localparam int unsigned NUM_W     = DAC_W + PHASE_W;
  localparam int unsigned DIVR_W    = PHASE_W;
  localparam int unsigned DIV_STEPS = NUM_W / 2;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DAC_W-1:0]    AMP_RESET    = DAC_W'(3722);
  localparam logic [DUTY_W-1:0]   DUTY_RESET   = DUTY_W'(50);
  localparam logic [DAC_W-1:0]    OFFSET_RESET = DAC_W'(248);
  localparam logic [DAC_W-1:0]    DAC_MAX      = '1;
  localparam logic [PHASE_W-1:0]  LAST_PHASE   = PHASE_W'(TABLE_LEN - 1);

  localparam longint unsigned SIN_A = 102944;
  localparam longint unsigned SIN_B = 42334;
  localparam longint unsigned SIN_C = 5223;
  localparam longint unsigned SIN_D = 307;

  typedef enum logic [MODE_W-1:0] {
    MODE_SQUARE = 2'd0,
    MODE_SINE   = 2'd1,
    MODE_TRI    = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_AMP    = 2'd1,
    CFG_DUTY   = 2'd2,
    CFG_OFFSET = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROM,
    BK_MUL,
    BK_SUM,
    BK_DIV,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DAC_W-1:0]  amp;
    logic [DUTY_W-1:0] duty;
    logic [DAC_W-1:0]  offset;
  } cfg_t;

  // one classified sample request
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               period_end;
    logic               in_rise;   // triangle rising segment
    logic               sq_high;   // square high level
    logic               neg_half;  // sine lower half
  } job_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               period_end;
    logic [DAC_W-1:0]   code;
  } result_t;

  // rise length 2*duty, capped at the table length
  function automatic logic [PHASE_W-1:0] rise_len(input logic [DUTY_W-1:0] d);
    logic [DUTY_W:0] tw;
    tw = {d, 1'b0};
    if (32'(tw) > TABLE_LEN) begin
      return PHASE_W'(TABLE_LEN);
    end
    return PHASE_W'(tw);
  endfunction

  function automatic logic [DAC_W-1:0] code_sat(input logic [WIDE_W-1:0] v);
    if (v > WIDE_W'(DAC_MAX)) begin
      return DAC_MAX;
    end
    return v[DAC_W-1:0];
  endfunction

  // Q16 sine magnitude for table point p, quadrant folded; elaboration only
  function automatic logic [SIN_W-1:0] sin_value(input int unsigned p);
    longint unsigned t4, q, r, x, x2, t;
    t4 = longint'(p) * 4;
    q  = (t4 / TABLE_LEN) & 3;
    r  = t4 % TABLE_LEN;
    if ((q & 1) != 0) begin
      r = TABLE_LEN - r;
    end
    x  = (r << SIN_FRAC) / TABLE_LEN;
    x2 = (x * x) >> SIN_FRAC;
    t  = SIN_D;
    t  = SIN_C - ((x2 * t) >> SIN_FRAC);
    t  = SIN_B - ((x2 * t) >> SIN_FRAC);
    t  = SIN_A - ((x2 * t) >> SIN_FRAC);
    t  = (x * t) >> SIN_FRAC;
    if (t > 65536) begin
      t = 65536;
    end
    return SIN_W'(t);
  endfunction

endpackage

>>> hdl/wsg_front.sv
// ----------------------------------------------------------------------------
// wsg_front
// Accepts sample ticks, tracks the phase and classifies each point.
// ----------------------------------------------------------------------------
module wsg_front
  import wsg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   tick_valid_i,
  output logic   tick_ready_o,
  input  logic   restart_i,
  input  logic   queue_full_i,
  output logic   push_o,
  output job_t   job_o
);

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [PHASE_W-1:0] p;
  logic [PHASE_W-1:0] rise;

  assign tick_ready_o = !queue_full_i;
  assign push_o       = tick_valid_i && !queue_full_i;

  always_comb begin
    p    = restart_i ? '0 : phase_q;
    rise = rise_len(cfg_i.duty);
    job_o.phase      = p;
    job_o.period_end = (p == LAST_PHASE);
    job_o.in_rise    = (p < rise);
    job_o.sq_high    = ({1'b0, p} <= {1'b0, cfg_i.duty, 1'b0});
    job_o.neg_half   = (32'({p, 1'b0}) >= TABLE_LEN);
    phase_d = phase_q;
    if (push_o) begin
      phase_d = (p == LAST_PHASE) ? '0 : p + PHASE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

>>> hdl/wsg_queue.sv
// ----------------------------------------------------------------------------
// wsg_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module wsg_queue
  import wsg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> hdl/wsg_div.sv
// ----------------------------------------------------------------------------
// wsg_div
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module wsg_div
  import wsg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DIVR_W-1:0] divisor_i,
  output logic              done_o,
  output logic [NUM_W-1:0]  quot_o
);

  logic [NUM_W-1:0]  num_q, quot_q;
  logic [DIVR_W-1:0] div_q, rem_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q, done_q;

  logic [DIVR_W:0]   r1, r2;
  logic [DIVR_W-1:0] r1n, r2n;
  logic              ge1, ge2;

  always_comb begin
    r1  = {rem_q, num_q[NUM_W-1]};
    ge1 = (r1 >= {1'b0, div_q});
    r1n = ge1 ? DIVR_W'(r1 - {1'b0, div_q}) : r1[DIVR_W-1:0];
    r2  = {r1n, num_q[NUM_W-2]};
    ge2 = (r2 >= {1'b0, div_q});
    r2n = ge2 ? DIVR_W'(r2 - {1'b0, div_q}) : r2[DIVR_W-1:0];
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DCNT_W'(1);
        if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      div_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NUM_W-3:0], 2'b00};
      rem_q  <= r2n;
      quot_q <= {quot_q[NUM_W-3:0], ge1, ge2};
    end
  end

endmodule

>>> hdl/wsg_back.sv
// ----------------------------------------------------------------------------
// wsg_back
// Computes the DAC code of each queued job and holds it in the output stage.
// ----------------------------------------------------------------------------
module wsg_back
  import wsg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    job_valid_i,
  input  job_t    job_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  back_state_e state_q, state_d;
  job_t        job_q, job_d;
  logic [SIN_W-1:0]  rom_q, rom_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [DAC_W-1:0]  code_q, code_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic [SIN_W-1:0]  sin_rom [TABLE_LEN];

  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num, div_quot;
  logic [DIVR_W-1:0] div_den;

  logic [PHASE_W-1:0] rise, span, fall_pos;
  logic [ACC_W-1:0]   base, acc;
  logic [DAC_W-1:0]   tq, tv;
  logic [WIDE_W-1:0]  tsum;

  for (genvar gi = 0; gi < TABLE_LEN; gi++) begin : g_rom
    assign sin_rom[gi] = sin_value(gi);
  end

  wsg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .num_i     (div_num),
    .divisor_i (div_den),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // triangle divider operands, taken from the job being popped
  always_comb begin
    rise     = rise_len(cfg_i.duty);
    span     = PHASE_W'(TABLE_LEN) - rise;
    fall_pos = job_i.phase - rise;
    if (job_i.in_rise) begin
      div_num = NUM_W'(cfg_i.amp) * NUM_W'(job_i.phase);
      div_den = rise;
    end else begin
      // ceil division: add span - 1 before dividing
      div_num = NUM_W'(cfg_i.amp) * NUM_W'(fall_pos) + NUM_W'(span) - NUM_W'(1);
      div_den = span;
    end
  end

  always_comb begin
    base = (ACC_W'(cfg_i.amp) << SIN_FRAC) + (ACC_W'(cfg_i.offset) << (SIN_FRAC + 1));
    acc  = job_q.neg_half ? base - ACC_W'(prod_q) : base + ACC_W'(prod_q);
    tq   = div_quot[DAC_W-1:0];
    if (job_q.in_rise) begin
      tv = tq;
    end else begin
      tv = (tq > cfg_i.amp) ? '0 : cfg_i.amp - tq;
    end
    tsum = WIDE_W'(tv) + WIDE_W'(cfg_i.offset);
  end

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    rom_d       = rom_q;
    prod_d      = prod_q;
    code_d      = code_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          case (mode_e'(cfg_i.mode))
            MODE_SQUARE: begin
              code_d  = job_i.sq_high ? cfg_i.amp : '0;
              state_d = BK_OUT;
            end
            MODE_SINE: begin
              state_d = BK_ROM;
            end
            MODE_TRI: begin
              div_start = 1'b1;
              state_d   = BK_DIV;
            end
            default: begin
              code_d  = '0;
              state_d = BK_OUT;
            end
          endcase
        end
      end
      BK_ROM: begin
        rom_d   = sin_rom[job_q.phase];
        state_d = BK_MUL;
      end
      BK_MUL: begin
        prod_d  = PROD_W'(cfg_i.amp) * PROD_W'(rom_q);
        state_d = BK_SUM;
      end
      BK_SUM: begin
        code_d  = code_sat(acc[ACC_W-1:SIN_FRAC+1]);
        state_d = BK_OUT;
      end
      BK_DIV: begin
        if (div_done) begin
          code_d  = code_sat(tsum);
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.phase      = job_q.phase;
          out_d.period_end = job_q.period_end;
          out_d.code       = code_q;
          out_valid_d      = 1'b1;
          state_d          = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    rom_q  <= rom_d;
    prod_q <= prod_d;
    code_q <= code_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> hdl/waveform_sample_generator.sv
// ----------------------------------------------------------------------------
// waveform_sample_generator
// Square, sine and triangle DAC code generator over a 200-point period.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick item per DAC sample; tdata bit 0 is restart,
//   which puts the phase back to zero before that sample.
//   m_axis returns one item per tick: tdata[11:0] is the DAC code,
//   tdata[19:12] the phase index, tlast marks the last point of a period.
//   cfg_we_i/cfg_idx_i/cfg_data_i write mode, amplitude, duty and offset;
//   write them only while no tick is in flight.
// Sequencing:
//   The back sequencer handles one item at a time. Square goes straight
//   to the output stage, sine passes the ROM read, the 12x17 multiply and
//   the sum, and triangle waits for the 10-step radix-4 divider.
// Reset:
//   Phase returns to 0 and the registers take their defaults (square, amp
//   3722, duty 50, offset 248); queue and output stage are emptied.
// Stall:
//   The output stage holds its item while m_axis_tready is low; the back
//   part waits, and the 2-entry queue lets the front keep taking ticks
//   until it fills, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module waveform_sample_generator
  import wsg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // tick items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [0] restart, [7:1] zero
  // sample items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [11:0] sample_code, [19:12] phase_index
  output logic                 m_axis_tlast    // period_end
);

  cfg_t    cfg_q;
  logic    push, full, pop, job_valid;
  job_t    job_in, job_out;
  result_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= MODE_W'(MODE_SQUARE);
      cfg_q.amp    <= AMP_RESET;
      cfg_q.duty   <= DUTY_RESET;
      cfg_q.offset <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:   cfg_q.mode   <= cfg_data_i[MODE_W-1:0];
        CFG_AMP:    cfg_q.amp    <= cfg_data_i[DAC_W-1:0];
        CFG_DUTY:   cfg_q.duty   <= cfg_data_i[DUTY_W-1:0];
        CFG_OFFSET: cfg_q.offset <= cfg_data_i[DAC_W-1:0];
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  // front: phase tracking and classification
  wsg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .tick_valid_i (s_axis_tvalid),
    .tick_ready_o (s_axis_tready),
    .restart_i    (s_axis_tdata[0]),
    .queue_full_i (full),
    .push_o       (push),
    .job_o        (job_in)
  );

  // decouples ticks from the sequencer
  wsg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  // back: waveform arithmetic and output stage
  wsg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {(M_TDATA_W - PHASE_W - DAC_W)'(0), res.phase, res.code};
  assign m_axis_tlast = res.period_end;

endmodule

>>> hdl/wsg_checker.sv
// ----------------------------------------------------------------------------
// wsg_checker
// Port-level checks of the sample generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsg_checker
  import wsg_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tlast
);

  // a stalled sample stays and holds still
  `WSG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "sample dropped while stalled")
  `WSG_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "sample changed while stalled")

  // phase stays inside the period and tlast flags its last point
  `WSG_ASSERT_NOW(a_phase_range, clk_i, rst_ni, m_axis_tvalid, 32'(m_axis_tdata[19:12]) < TABLE_LEN, "phase index out of range")
  `WSG_ASSERT_NOW(a_last_match, clk_i, rst_ni, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[19:12] == LAST_PHASE), "tlast does not match phase")

endmodule

bind waveform_sample_generator wsg_checker u_wsg_checker (.*);
